@@ hdl/igqdp_pkg.sv @@
// Package: shared types and FP32 helper functions for the group-quantised dot product.
package igqdp_pkg;

    // Group-close or row-end job handed from the front end to the scaling back end
    typedef struct packed {
        logic [23:0] gsum;
        logic [31:0] ws;
        logic [31:0] as;
        logic        close;
        logic        emit;
    } job_t;

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    // Signed 24-bit integer to FP32, round to nearest even
    function automatic logic [31:0] i2f(input logic [23:0] v);
        logic        s;
        logic [23:0] a;
        logic [4:0]  lz;
        logic [23:0] n;
        logic [7:0]  e;
        s = v[23];
        a = s ? (~v + 24'd1) : v;
        lz = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (a[i]) lz = 5'(23 - i);
        end
        n = a << lz;
        if (a == 24'd0) begin
            i2f = 32'd0;
        end else begin
            // value = n * 2^(23-lz-23); 24-bit input magnitude fits 24 bits exactly
            e = 8'(127 + 23 - 32'(lz));
            i2f = {s, e, n[22:0]};
        end
    endfunction

    // FP32 multiply, round to nearest even, with subnormals
    function automatic logic [31:0] fmul(input logic [31:0] x, input logic [31:0] y);
        logic        s;
        logic [7:0]  ex, ey;
        logic [23:0] mx, my;
        logic [47:0] p;
        logic signed [11:0] e;
        logic [5:0]  lz;
        logic [49:0] q;
        logic [24:0] mr;
        logic        g, st;
        int          sh;
        s = x[31] ^ y[31];
        ex = x[30:23];
        ey = y[30:23];
        mx = {ex != 8'd0, x[22:0]};
        my = {ey != 8'd0, y[22:0]};
        if ((ex == 8'hFF && x[22:0] != 0) || (ey == 8'hFF && y[22:0] != 0)) begin
            fmul = QNAN;
        end else if (ex == 8'hFF || ey == 8'hFF) begin
            if ((ex == 8'hFF && y[30:0] == 0) || (ey == 8'hFF && x[30:0] == 0))
                fmul = QNAN;
            else
                fmul = {s, 8'hFF, 23'd0};
        end else begin
            p = mx * my;
            if (p == 48'd0) begin
                fmul = {s, 31'd0};
            end else begin
                lz = 6'd0;
                for (int i = 0; i < 48; i++) begin
                    if (p[i]) lz = 6'(47 - i);
                end
                // value = p * 2^(ex'+ey'-254-46)
                e = 12'(32'(ex == 0 ? 1 : ex) + 32'(ey == 0 ? 1 : ey) - 126) - 12'(lz);
                q = {p << lz, 2'b00};
                if (e < 12'sd1) begin
                    sh = 1 - int'(e);
                    if (sh > 49) sh = 49;
                    st = 1'b0;
                    for (int i = 0; i < 50; i++) begin
                        if (i < sh && q[i]) st = 1'b1;
                    end
                    q = q >> sh;
                    q[0] = q[0] | st;
                    e = 12'sd0;
                end
                // q[49:26] = 24-bit mantissa, q[25] guard, rest sticky
                g = q[25];
                st = |q[24:0];
                mr = {1'b0, q[49:26]};
                if (g && (st || mr[0])) mr = mr + 25'd1;
                if (mr[24]) begin
                    mr = mr >> 1;
                    e = e + 12'sd1;
                end else if (e == 12'sd0 && mr[23]) begin
                    e = 12'sd1;
                end
                if (e >= 12'sd255)
                    fmul = {s, 8'hFF, 23'd0};
                else
                    fmul = {s, e[7:0], mr[22:0]};
            end
        end
    endfunction

    // FP32 add, round to nearest even
    function automatic logic [31:0] fadd(input logic [31:0] x, input logic [31:0] y);
        logic [7:0]  ex, ey, eb;
        logic [26:0] ma, mb;
        logic [27:0] sm;
        logic [31:0] big, sml;
        logic        sb, st, g;
        logic [4:0]  lz;
        logic signed [10:0] e;
        logic [24:0] mr;
        int          d;
        ex = x[30:23];
        ey = y[30:23];
        if ((ex == 8'hFF && x[22:0] != 0) || (ey == 8'hFF && y[22:0] != 0)) begin
            fadd = QNAN;
        end else if (ex == 8'hFF && ey == 8'hFF) begin
            fadd = (x[31] != y[31]) ? QNAN : x;
        end else if (ex == 8'hFF) begin
            fadd = x;
        end else if (ey == 8'hFF) begin
            fadd = y;
        end else begin
            if (x[30:0] >= y[30:0]) begin
                big = x; sml = y;
            end else begin
                big = y; sml = x;
            end
            eb = big[30:23] == 0 ? 8'd1 : big[30:23];
            ma = {big[30:23] != 0, big[22:0], 3'b000};
            mb = {sml[30:23] != 0, sml[22:0], 3'b000};
            d = int'(eb) - int'(sml[30:23] == 0 ? 8'd1 : sml[30:23]);
            st = 1'b0;
            for (int i = 0; i < 27; i++) begin
                if (i < d && mb[i]) st = 1'b1;
            end
            mb = (d > 26) ? 27'd0 : mb >> d;
            mb[0] = mb[0] | st;
            sb = big[31];
            if (big[31] == sml[31]) sm = {1'b0, ma} + {1'b0, mb};
            else sm = {1'b0, ma} - {1'b0, mb};
            if (sm == 28'd0) begin
                fadd = {x[31] & y[31], 31'd0};
            end else begin
                e = 11'(eb);
                if (sm[27]) begin
                    sm = {1'b0, sm[27:2], sm[1] | sm[0]};
                    e = e + 11'sd1;
                end
                lz = 5'd0;
                for (int i = 0; i < 27; i++) begin
                    if (sm[i]) lz = 5'(26 - i);
                end
                if (11'(lz) > e - 11'sd1) lz = 5'(e - 11'sd1);
                sm = sm << lz;
                e = e - 11'(lz);
                if (!sm[26]) e = 11'sd0;
                g = sm[2];
                st = sm[1] | sm[0];
                mr = {1'b0, sm[26:3]};
                if (g && (st || mr[0])) mr = mr + 25'd1;
                if (mr[24]) begin
                    mr = mr >> 1;
                    e = e + 11'sd1;
                end else if (e == 11'sd0 && mr[23]) begin
                    e = 11'sd1;
                end
                if (e >= 11'sd255) fadd = {sb, 8'hFF, 23'd0};
                else fadd = {sb, e[7:0], mr[22:0]};
            end
        end
    endfunction

endpackage

@@ hdl/igqdp_front.sv @@
// Front end: integer group accumulation and classification of each element.
module igqdp_front #(
    parameter int MAX_GROUP = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [8:0]           grp_len,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           act_value,
    input  logic [7:0]           weight_value,
    input  logic [31:0]          act_scale,
    input  logic [31:0]          weight_scale,
    input  logic                 row_end,
    output logic                 job_valid,
    input  logic                 job_ready,
    output igqdp_pkg::job_t      job
);
    localparam int CW = $clog2(MAX_GROUP + 1);

    logic [23:0]   gsum_reg, gsum_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] eff;
    logic [23:0]   prod;
    logic [CW-1:0] cnt_inc;
    logic          close;
    logic          fire;

    // Effective group size, clamped to one..MAX_GROUP
    always_comb begin
        if (grp_len == 9'd0) eff = CW'(1);
        else if (32'(grp_len) > MAX_GROUP) eff = CW'(MAX_GROUP);
        else eff = CW'(grp_len);
    end

    assign prod    = 24'($signed(act_value) * $signed(weight_value));
    assign cnt_inc = cnt_reg + CW'(1);
    assign close   = cnt_inc >= eff;
    assign in_ready = job_ready;
    assign fire    = in_valid && in_ready;

    // Only elements that close a group or a row produce a job
    assign job_valid  = in_valid && (close || row_end);
    assign job.gsum   = gsum_reg + prod;
    assign job.ws     = weight_scale;
    assign job.as     = act_scale;
    assign job.close  = close;
    assign job.emit   = row_end;

    always_comb begin
        gsum_next = gsum_reg;
        cnt_next  = cnt_reg;
        if (fire) begin
            if (close || row_end) begin
                gsum_next = 24'd0;
                cnt_next  = '0;
            end else begin
                gsum_next = gsum_reg + prod;
                cnt_next  = cnt_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gsum_reg <= 24'd0;
            cnt_reg  <= '0;
        end else begin
            gsum_reg <= gsum_next;
            cnt_reg  <= cnt_next;
        end
    end
endmodule

@@ hdl/igqdp_queue.sv @@
// Short job queue between front end and back end.
module igqdp_queue #(
    parameter int DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  igqdp_pkg::job_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output igqdp_pkg::job_t rd_data
);
    localparam int AW = $clog2(DEPTH);

    igqdp_pkg::job_t   mem [DEPTH];
    logic [AW-1:0]     wp_reg, rp_reg;
    logic [AW:0]       cnt_reg;
    logic              wr, rd;

    assign wr_ready = cnt_reg != (AW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem[rp_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (wr) mem[wp_reg] <= wr_data;
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            if (rd) rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end
endmodule

@@ hdl/igqdp_back.sv @@
// Back end: FP32 scaling sequencer, row accumulation and result register.
module igqdp_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            job_valid,
    output logic            job_ready,
    input  igqdp_pkg::job_t job,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [31:0]     m_tdata
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_MULW = 3'd2;
    localparam logic [2:0] S_MULA = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]       st_reg, st_next;
    igqdp_pkg::job_t  j_reg;
    logic [31:0]      t_reg;
    logic [31:0]      acc_reg;
    logic [31:0]      res_reg;
    logic             ov_reg;

    assign job_ready = st_reg == S_IDLE;
    assign m_tvalid  = ov_reg;
    assign m_tdata   = res_reg;

    // Sequencer: one FP step per cycle
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: if (job_valid) st_next = job.close ? S_CONV : S_OUT;
            S_CONV: st_next = S_MULW;
            S_MULW: st_next = S_MULA;
            S_MULA: st_next = S_ADD;
            S_ADD:  st_next = j_reg.emit ? S_OUT : S_IDLE;
            S_OUT:  if (!ov_reg || m_tready) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (st_reg == S_IDLE && job_valid) j_reg <= job;
        case (st_reg)
            S_CONV: t_reg <= igqdp_pkg::i2f(j_reg.gsum);
            S_MULW: t_reg <= igqdp_pkg::fmul(t_reg, j_reg.ws);
            S_MULA: t_reg <= igqdp_pkg::fmul(t_reg, j_reg.as);
            default: t_reg <= t_reg;
        endcase
        if (st_reg == S_OUT && (!ov_reg || m_tready)) res_reg <= acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= S_IDLE;
            acc_reg <= 32'd0;
            ov_reg  <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (st_reg == S_ADD) acc_reg <= igqdp_pkg::fadd(acc_reg, t_reg);
            if (st_reg == S_OUT && (!ov_reg || m_tready)) begin
                acc_reg <= 32'd0;
                ov_reg  <= 1'b1;
            end else if (m_tready) begin
                ov_reg <= 1'b0;
            end
        end
    end
endmodule

@@ hdl/int8_group_quantized_dot_product.sv @@
// Top level: int8 group-quantised dot product with FP32 group scaling.
//
//  channel  dir  fields (tdata low bit up)
//  s_       in   act_value[7:0], weight_value[15:8], act_scale[47:16],
//                weight_scale[79:48]; tlast = row_end
//  m_       out  row_value[31:0]
//  cfg      in   elements per group (9 bits)
//
// Elements that neither close a group nor end a row only add to the group sum.
// A group close runs the FP sequencer steps accept, convert, two multiplies, add;
// a row end adds an output step, held while a result waits and m_tready is low.
// Up to four jobs wait in the queue; s_tready drops while it is full.
// Reset is synchronous, active low.
module int8_group_quantized_dot_product #(
    parameter int MAX_GROUP = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // act_value, weight_value, act_scale, weight_scale
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // row_value
);
    logic [8:0]       gs_reg;
    logic             fj_valid, fj_ready, bj_valid, bj_ready;
    igqdp_pkg::job_t  fj, bj;

    always_ff @(posedge aclk) begin
        if (!aresetn) gs_reg <= 9'd64;
        else if (cfg_we) gs_reg <= cfg_wdata;
    end

    igqdp_front #(.MAX_GROUP(MAX_GROUP)) u_front (
        .aclk, .aresetn, .grp_len(gs_reg),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .act_value(s_tdata[7:0]), .weight_value(s_tdata[15:8]),
        .act_scale(s_tdata[47:16]), .weight_scale(s_tdata[79:48]),
        .row_end(s_tlast),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    igqdp_queue #(.DEPTH(4)) u_queue (
        .aclk, .aresetn,
        .wr_valid(fj_valid && s_tvalid), .wr_ready(fj_ready), .wr_data(fj),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
    );

    igqdp_back u_back (
        .aclk, .aresetn,
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .m_tvalid, .m_tready, .m_tdata
    );
endmodule
